@@ hdl/e2d_pkg.sv @@
// Shared types, constants and the month length table for the epoch to date converter.
// Used by e2d_ctrl, e2d_dp and epoch_seconds_to_date; depends on nothing else.
`timescale 1ns / 1ps

package e2d_pkg;

  localparam int SecondsWidthDefault = 32;
  localparam int SecsPerDay          = 86400;
  localparam int EpochYear           = 1970;
  localparam int LeapYearDays        = 366;
  localparam int CommonYearDays      = 365;
  localparam int EpochMod100         = EpochYear % 100;
  localparam int EpochMod400         = EpochYear % 400;

  localparam int YearOutWidth  = 12;
  localparam int MonthOutWidth = 4;
  localparam int DayOutWidth   = 5;

  localparam logic [MonthOutWidth-1:0] LastMonthIdx = MonthOutWidth'(11);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic year_step;
    logic month_step;
    logic out_load;
  } e2d_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic year_done;
    logic month_done;
  } e2d_sts_t;

  // Length of a month, given its zero-based index and whether the year is a leap year.
  function automatic logic [DayOutWidth-1:0] month_len(input logic [MonthOutWidth-1:0] idx,
                                                       input logic leap);
    logic [DayOutWidth-1:0] len;
    unique case (idx)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = DayOutWidth'(31);
      4'd3, 4'd5, 4'd8, 4'd10:                   len = DayOutWidth'(30);
      4'd1:                                       len = leap ? DayOutWidth'(29)
                                                             : DayOutWidth'(28);
      default:                                    len = DayOutWidth'(31);
    endcase
    return len;
  endfunction

endpackage

@@ hdl/e2d_ctrl.sv @@
// Controller state machine of the epoch to date converter.
// Sequences the year and month phases and owns both handshakes; uses e2d_pkg.
`timescale 1ns / 1ps

module e2d_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  e2d_pkg::e2d_sts_t sts_i,
  output e2d_pkg::e2d_cmd_t cmd_o
);
  import e2d_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StYear  = 2'd1;
  localparam logic [1:0] StMonth = 2'd2;
  localparam logic [1:0] StHold  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StYear;
        end
      end
      StYear: begin
        if (sts_i.year_done) begin
          state_d = StMonth;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      StMonth: begin
        if (sts_i.month_done) begin
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = StIdle;
          end else begin
            state_d = StHold;
          end
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      StHold: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/e2d_dp.sv @@
// Datapath of the epoch to date converter: year and month subtractors on the seconds with
// leap tracking, the day of month by reciprocal multiplication, and the output register.
// Uses e2d_pkg.
`timescale 1ns / 1ps

module e2d_dp #(
  parameter int SECONDS_WIDTH = e2d_pkg::SecondsWidthDefault
) (
  input  logic                                 clk_i,
  input  logic [SECONDS_WIDTH-1:0]             epoch_seconds_i,
  input  e2d_pkg::e2d_cmd_t                    cmd_i,
  output e2d_pkg::e2d_sts_t                    sts_o,
  output logic [e2d_pkg::YearOutWidth-1:0]     year_o,
  output logic [e2d_pkg::MonthOutWidth-1:0]    month_o,
  output logic [e2d_pkg::DayOutWidth-1:0]      day_o
);
  import e2d_pkg::*;

  // A day is longer than 2^16 seconds, so the day count needs 16 bits fewer than the seconds.
  localparam int DaysW  = SECONDS_WIDTH - 16;
  localparam int YearW  = $clog2(EpochYear + (2 ** DaysW) / CommonYearDays + 2);

  localparam logic [SECONDS_WIDTH-1:0] LeapYearSecs   =
    SECONDS_WIDTH'(LeapYearDays * SecsPerDay);
  localparam logic [SECONDS_WIDTH-1:0] CommonYearSecs =
    SECONDS_WIDTH'(CommonYearDays * SecsPerDay);

  // After the month loop fewer than 31 days of seconds remain, which fits in 22 bits.
  // Since 86400 is 128 times 675, the whole days are the seconds shifted right by 7 and
  // then multiplied by ceil(2^24 / 675) and shifted right by 24; the rounding error stays
  // below one for every value that can reach this point.
  localparam int                RemW       = 22;
  localparam int                PreShift   = 7;
  localparam int                RecipW     = RemW - PreShift;
  localparam int                RecipShift = 24;
  localparam logic [RecipW-1:0] Recip675   = RecipW'(24856);

  logic [SECONDS_WIDTH-1:0] secs_q;
  logic [YearW-1:0]         year_q;
  logic [6:0]               mod100_q;
  logic [8:0]               mod400_q;
  logic [MonthOutWidth-1:0] month_q;

  logic                     leap;
  logic [SECONDS_WIDTH-1:0] year_secs;
  logic [DayOutWidth-1:0]   mon_len;
  logic [SECONDS_WIDTH-1:0] mon_secs;
  logic                     year_fits;
  logic                     month_fits;
  logic [RecipW-1:0]        day_x;
  logic [2*RecipW-1:0]      day_prod;

  // Leap rule from the running year residues modulo 100 and 400.
  assign leap = ((mod400_q[1:0] == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);

  assign year_secs  = leap ? LeapYearSecs : CommonYearSecs;
  assign year_fits  = secs_q >= year_secs;
  assign mon_len    = month_len(month_q, leap);
  assign mon_secs   = SECONDS_WIDTH'(mon_len) * SECONDS_WIDTH'(SecsPerDay);
  assign month_fits = secs_q >= mon_secs;

  assign day_x    = secs_q[RemW-1:PreShift];
  assign day_prod = (2*RecipW)'(day_x) * (2*RecipW)'(Recip675);

  assign sts_o.year_done  = !year_fits;
  assign sts_o.month_done = (month_q == LastMonthIdx) || !month_fits;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      secs_q   <= epoch_seconds_i;
      year_q   <= YearW'(EpochYear);
      mod100_q <= 7'(EpochMod100);
      mod400_q <= 9'(EpochMod400);
      month_q  <= '0;
    end
    if (cmd_i.year_step) begin
      secs_q   <= secs_q - year_secs;
      year_q   <= year_q + YearW'(1);
      mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
      mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
    end
    if (cmd_i.month_step) begin
      secs_q  <= secs_q - mon_secs;
      month_q <= month_q + MonthOutWidth'(1);
    end
    if (cmd_i.out_load) begin
      year_o  <= year_q[YearOutWidth-1:0];
      month_o <= month_q + MonthOutWidth'(1);
      day_o   <= day_prod[RecipShift +: DayOutWidth] + DayOutWidth'(1);
    end
  end

endmodule

@@ hdl/epoch_seconds_to_date.sv @@
// One transaction is in flight at a time: whole years and then whole months of seconds are
// removed, one a cycle, by the year and month subtractors, and the result is loaded into the
// output register, waiting while that register is still occupied; the next transaction is
// taken the cycle after that load. Reset clears the controller and the output valid flag;
// no result is pending after reset.
`timescale 1ns / 1ps

module epoch_seconds_to_date #(
  parameter int SECONDS_WIDTH = e2d_pkg::SecondsWidthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [SECONDS_WIDTH-1:0]          epoch_seconds_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [e2d_pkg::YearOutWidth-1:0]  year_o,
  output logic [e2d_pkg::MonthOutWidth-1:0] month_o,
  output logic [e2d_pkg::DayOutWidth-1:0]   day_o
);
  import e2d_pkg::*;

  // The controller steps through two phases for each transaction, working on the seconds
  // directly. First whole years are removed one per cycle, starting at 1970, by subtracting
  // the year's length in seconds, while the leap rule is tracked with running residues of
  // the year modulo 100 and 400, so no division of the year is ever needed. Next, whole
  // months are removed one per cycle, with February lengthened in leap years. What is left
  // is less than a month; it is turned into whole days by a shift and a multiplication by a
  // reciprocal as the result is loaded, the time of day is dropped, and the days plus one
  // give the day of month.

  e2d_cmd_t cmd;
  e2d_sts_t sts;

  e2d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The result is held in the datapath's output register until the downstream transaction
  // completes, so a new input can be worked on meanwhile.
  e2d_dp #(
    .SECONDS_WIDTH (SECONDS_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .epoch_seconds_i (epoch_seconds_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .year_o          (year_o),
    .month_o         (month_o),
    .day_o           (day_o)
  );

endmodule
